/* rtl/assert_macros.svh */
// Assertion macros shared by the LED brightness fader RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define LBF_ASSERT(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("lbf assertion failed");

// Same-cycle implication.
`define LBF_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons) \
  `LBF_ASSERT(lbl, clk_sig, rstn_sig, (ante) |-> (cons))

// Next-cycle implication.
`define LBF_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons) \
  `LBF_ASSERT(lbl, clk_sig, rstn_sig, (ante) |=> (cons))

`endif

/* rtl/lbf_pkg.sv */
// Types and constants for the LED brightness fader.
// No dependencies; imported by lbf_update and led_brightness_fader.
package lbf_pkg;

  localparam int LVL_W     = 15;
  localparam int TICK_W    = 32;
  localparam int INTV_W    = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Fixed timing/scaling constants, all powers of two.
  localparam int FADE_STEP_DIV   = 8;
  localparam int FLASH_PERIOD_MS = 1024;
  localparam int FLASH_ON_MS     = 512;
  localparam int FLASH_LEVEL_DIV = 4;

  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CRIT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_INTV  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_EN   = 2'd2;

  localparam logic [LVL_W-1:0]  DIM_TARGET_RST = 15'd100;
  localparam logic [INTV_W-1:0] FADE_INTV_RST  = 16'd10;

  typedef logic [LVL_W-1:0] level_t;

  typedef struct packed {
    logic              func;
    level_t            target_brightness;
    logic              smooth;
    logic [TICK_W-1:0] tick_ms;
    logic [MODE_W-1:0] system_mode;
    logic              dimmed;
  } lbf_item_t;

  typedef struct packed {
    level_t            current_level;
    level_t            stored_target;
    logic              smooth_enabled;
    logic [TICK_W-1:0] last_step_time;
  } lbf_state_t;

  typedef struct packed {
    level_t            dim_target;
    logic [INTV_W-1:0] fade_interval_ms;
    logic              flash_warning_enable;
  } lbf_cfg_t;

  typedef struct packed {
    level_t brightness;
    logic   output_off;
    logic   flash_phase;
  } lbf_result_t;

endpackage

/* rtl/lbf_update.sv */
// Next-state and result logic for one fader item.
// Depends on lbf_pkg.
module lbf_update (
  input  lbf_pkg::lbf_item_t   item,
  input  lbf_pkg::lbf_state_t  state,
  input  lbf_pkg::lbf_cfg_t    cfg,
  output lbf_pkg::lbf_state_t  state_nxt,
  output lbf_pkg::lbf_result_t result
);
  import lbf_pkg::*;

  level_t            tgt;
  level_t            mag;
  level_t            step;
  level_t            faded;
  level_t            cur_new;
  logic              up;
  logic [TICK_W-1:0] elapsed;
  logic              due;
  logic              flash;

  assign tgt     = item.dimmed ? cfg.dim_target : state.stored_target;
  assign up      = tgt > state.current_level;
  assign mag     = up ? (tgt - state.current_level) : (state.current_level - tgt);
  // |diff| / DIV truncates toward zero; small gaps move by one unit
  assign step    = (mag > LVL_W'(FADE_STEP_DIV)) ? LVL_W'(mag / FADE_STEP_DIV) : LVL_W'(1);
  assign faded   = up ? (state.current_level + step) : (state.current_level - step);
  assign elapsed = item.tick_ms - state.last_step_time;
  assign due     = elapsed >= {{(TICK_W-INTV_W){1'b0}}, cfg.fade_interval_ms};

  assign flash = (item.system_mode == MODE_CRIT) && cfg.flash_warning_enable &&
                 (item.tick_ms % FLASH_PERIOD_MS < FLASH_ON_MS);

  always_comb begin
    state_nxt = state;
    cur_new   = state.current_level;
    result    = '0;
    if (item.func == FUNC_SET) begin
      state_nxt.stored_target  = item.target_brightness;
      state_nxt.smooth_enabled = item.smooth;
    end else if (item.system_mode == MODE_OFF) begin
      result.output_off = 1'b1;
    end else begin
      state_nxt.stored_target = tgt;
      if (state.smooth_enabled && (state.current_level != tgt)) begin
        if (due) begin
          cur_new                  = faded;
          state_nxt.last_step_time = item.tick_ms;
        end
      end else begin
        cur_new = tgt;
      end
      state_nxt.current_level = cur_new;
      result.flash_phase      = flash;
      result.brightness       = flash ? LVL_W'(cur_new / FLASH_LEVEL_DIV) : cur_new;
    end
  end

endmodule

/* rtl/led_brightness_fader.sv */
// LED brightness fader: takes one item per clock unless stalled, fades the current
// level toward the stored target and reports one result per update tick. An
// accepted item is held in the input register, and a tick's result is loaded
// into the output register when the item advances, from where it can transfer
// out. in_stall rises only while a tick waits in the input register and the
// output register holds a result that is stalled; otherwise a new item is taken
// every cycle.
// Depends on lbf_pkg, lbf_update and assert_macros.svh.
module led_brightness_fader (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [lbf_pkg::LVL_W-1:0]     in_target_brightness,
  input  logic                          in_smooth,
  input  logic [lbf_pkg::TICK_W-1:0]    in_tick_ms,
  input  logic [lbf_pkg::MODE_W-1:0]    in_system_mode,
  input  logic                          in_dimmed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lbf_pkg::LVL_W-1:0]     out_brightness,
  output logic                          out_output_off,
  output logic                          out_flash_phase
);
  import lbf_pkg::*;
  `include "assert_macros.svh"

  lbf_cfg_t    cfg_r;
  lbf_state_t  state_r;
  lbf_state_t  state_nxt;
  lbf_item_t   s1_r;
  logic        s1_valid_r;
  logic        s1_adv;
  logic        in_xfer;
  lbf_result_t res;
  lbf_result_t out_r;
  logic        out_valid_r;

  // configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_target           <= DIM_TARGET_RST;
      cfg_r.fade_interval_ms     <= FADE_INTV_RST;
      cfg_r.flash_warning_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIM_TARGET: cfg_r.dim_target           <= cfg_wdata[LVL_W-1:0];
        CFG_FADE_INTV:  cfg_r.fade_interval_ms     <= cfg_wdata[INTV_W-1:0];
        CFG_FLASH_EN:   cfg_r.flash_warning_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // a set-target item never needs the output register
  assign s1_adv   = s1_valid_r && ((s1_r.func == FUNC_SET) || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.func              <= in_func;
      s1_r.target_brightness <= in_target_brightness;
      s1_r.smooth            <= in_smooth;
      s1_r.tick_ms           <= in_tick_ms;
      s1_r.system_mode       <= in_system_mode;
      s1_r.dimmed            <= in_dimmed;
    end
  end

  lbf_update u_update (
    .item      (s1_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && (s1_r.func == FUNC_TICK)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_r.func == FUNC_TICK)) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_brightness  = out_r.brightness;
  assign out_output_off  = out_r.output_off;
  assign out_flash_phase = out_r.flash_phase;

  `LBF_ASSERT_IMP(a_full_blocks_tick, clk, rst_n,
    s1_valid_r && (s1_r.func == FUNC_TICK) && out_valid_r && out_stall, in_stall)
  `LBF_ASSERT_NXT(a_off_keeps_state, clk, rst_n,
    s1_adv && (s1_r.func == FUNC_TICK) && (s1_r.system_mode == MODE_OFF), $stable(state_r))
  `LBF_ASSERT_NXT(a_set_stores_target, clk, rst_n, s1_adv && (s1_r.func == FUNC_SET),
    state_r.stored_target == $past(s1_r.target_brightness))
  `LBF_ASSERT_IMP(a_off_result_dark, clk, rst_n, out_valid_r && out_r.output_off,
    (out_r.brightness == '0) && !out_r.flash_phase)

endmodule
